// File: src/srr_pkg.sv
// ----------------------------------------------------------------------------
// srr_pkg
// Shared types and constants for the selective-repeat receiver core.
// ----------------------------------------------------------------------------
package srr_pkg;

  localparam int SEQ_W        = 3;   // sequence number field width
  localparam int DATA_W       = 64;  // payload / data field width
  localparam int CFG_W        = 4;   // window_size register width
  localparam int TDATA_W      = 72;  // seq/ack + payload, padded to bytes
  localparam int MAX_RESULTS  = 9;
  localparam int MAX_DELIV    = MAX_RESULTS - 1;
  localparam int DCNT_W       = $clog2(MAX_RESULTS);

  localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(4);

  localparam logic KIND_ACK     = 1'b0;
  localparam logic KIND_DELIVER = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic capture;    // latch the incoming packet
    logic eval_load;  // emit the ack, store the packet if it is in the window
    logic rd_en;      // read the slot at window base
    logic dlv_load;   // emit the delivery, clear the slot, advance base
  } srr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic ok;         // captured packet passed its checksum
    logic more_ack;   // a delivery follows the ack
    logic more_dlv;   // another delivery follows this one
    logic out_free;   // output register can take a result this cycle
  } srr_status_t;

endpackage

// File: src/srr_ram.sv
// ----------------------------------------------------------------------------
// srr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module srr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/srr_ctrl.sv
// ----------------------------------------------------------------------------
// srr_ctrl
// Sequencer: one packet at a time; acks a good one, then walks the in-order run.
// ----------------------------------------------------------------------------
module srr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  srr_pkg::srr_status_t st,
  output srr_pkg::srr_cmd_t    cmd
);

  import srr_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EVAL = 4'b0010,
    ST_READ = 4'b0100,
    ST_DLV  = 4'b1000
  } state_t;

  state_t state, state_next;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.capture   = s_tvalid && (state == ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        // drop a packet with a bad checksum
        if (!st.ok) begin
          state_next = ST_IDLE;
        end else if (st.out_free) begin
          cmd.eval_load = 1'b1;
          state_next    = st.more_ack ? ST_READ : ST_IDLE;
        end
      end
      ST_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = ST_DLV;
      end
      ST_DLV: begin
        if (st.out_free) begin
          cmd.dlv_load = 1'b1;
          state_next   = st.more_dlv ? ST_READ : ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: src/srr_dp.sv
// ----------------------------------------------------------------------------
// srr_dp
// Datapath: window base, received bits, reorder RAM and the result register.
// ----------------------------------------------------------------------------
module srr_dp #(
  parameter int SEQ_SPACE    = 8,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [srr_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic [srr_pkg::SEQ_W-1:0]     seq_num,
  input  logic                          checksum_ok,
  input  logic [srr_pkg::DATA_W-1:0]    payload,
  input  srr_pkg::srr_cmd_t             cmd,
  output srr_pkg::srr_status_t          st,
  input  logic                          m_tready,
  output logic                          m_tvalid,
  output logic                          out_kind,
  output logic [srr_pkg::SEQ_W-1:0]     out_ack,
  output logic [srr_pkg::DATA_W-1:0]    out_data,
  output logic                          out_last
);

  import srr_pkg::*;

  localparam int AW = $clog2(SEQ_SPACE);
  localparam int CW = ((AW > SEQ_W) ? AW : SEQ_W) + 1;
  localparam int DW = ((AW > CFG_W) ? AW : CFG_W) + 1;
  localparam logic [AW-1:0] BASE_LAST = AW'(SEQ_SPACE - 1);

  logic [CFG_W-1:0]        window_size;
  logic [AW-1:0]           base;
  logic [SEQ_SPACE-1:0]    rcv;
  logic [DCNT_W-1:0]       dcount;
  logic                    out_valid;

  logic [SEQ_W-1:0]        seq_r;
  logic                    ok_r;
  logic [PAYLOAD_BITS-1:0] pay_r;

  logic [AW-1:0]           seq_idx;
  logic [AW-1:0]           base_inc;
  logic [DW-1:0]           win_off;
  logic                    in_space;
  logic                    in_win;
  logic [PAYLOAD_BITS-1:0] rd_data;

  assign seq_idx  = AW'(seq_r);
  assign in_space = CW'(seq_r) < CW'(SEQ_SPACE);
  assign base_inc = (base == BASE_LAST) ? '0 : AW'(base + 1'b1);

  // distance from base, modulo the sequence space
  always_comb begin
    if (seq_idx >= base) begin
      win_off = DW'(seq_idx) - DW'(base);
    end else begin
      win_off = DW'(seq_idx) + DW'(SEQ_SPACE) - DW'(base);
    end
  end

  assign in_win = in_space && (win_off < DW'(window_size));

  assign st.ok       = ok_r;
  assign st.more_ack = in_win && ((seq_idx == base) || rcv[base]);
  assign st.more_dlv = (DCNT_W'(dcount + 1'b1) < DCNT_W'(MAX_DELIV)) && rcv[base_inc];
  assign st.out_free = !out_valid || m_tready;

  assign m_tvalid = out_valid;

  srr_ram #(
    .WIDTH (PAYLOAD_BITS),
    .DEPTH (SEQ_SPACE)
  ) u_slot_ram (
    .clk   (clk),
    .we    (cmd.eval_load && in_win),
    .waddr (seq_idx),
    .wdata (pay_r),
    .re    (cmd.rd_en),
    .raddr (base),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WINDOW_RESET;
      base        <= '0;
      rcv         <= '0;
      dcount      <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        window_size <= cfg_wdata;
      end
      if (cmd.eval_load || cmd.dlv_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      if (cmd.eval_load) begin
        dcount <= '0;
        if (in_win) begin
          rcv[seq_idx] <= 1'b1;
        end
      end
      if (cmd.dlv_load) begin
        rcv[base] <= 1'b0;
        base      <= base_inc;
        dcount    <= DCNT_W'(dcount + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      seq_r <= seq_num;
      ok_r  <= checksum_ok;
      pay_r <= payload[PAYLOAD_BITS-1:0];
    end
    if (cmd.eval_load) begin
      out_kind <= KIND_ACK;
      out_ack  <= seq_r;
      out_data <= '0;
      out_last <= !st.more_ack;
    end else if (cmd.dlv_load) begin
      out_kind <= KIND_DELIVER;
      out_ack  <= '0;
      out_data <= DATA_W'(rd_data);
      out_last <= !st.more_dlv;
    end
  end

endmodule

// File: src/selective_repeat_receiver_core.sv
// ----------------------------------------------------------------------------
// selective_repeat_receiver_core
// Selective-repeat ARQ receiver with reorder buffer and in-order delivery.
// ----------------------------------------------------------------------------
// Packets enter on the s_ stream: seq_num and payload in tdata, checksum_ok
// in tuser. Results leave on the m_ stream: tuser is the kind (0 = ack,
// 1 = delivery), tdata carries ack_num and data, tlast marks the final
// result of a packet. A bad-checksum packet produces nothing; one outside
// the window gets a single echo ack; one inside is stored, acked, and then
// the run of received slots from the window base is delivered in order.
// One packet is handled at a time. A packet is accepted, then evaluated, and
// each delivery waits for a registered read of the reorder RAM at the window
// base. s_tready returns high once the last result is loaded into the output
// register. A stalled m_tready holds the controller in place; nothing is lost.
// cfg_we writes window_size; the user must write it only while idle, which the
// block does not enforce. Reset (rst, synchronous) sets window_size to 4, the
// base to zero and clears all received marks; the RAM needs no clearing.
// ----------------------------------------------------------------------------
module selective_repeat_receiver_core #(
  parameter int SEQ_SPACE    = 8,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [srr_pkg::CFG_W-1:0]     cfg_wdata,   // window_size
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [srr_pkg::TDATA_W-1:0]   s_tdata,     // seq_num[2:0], payload[66:3]
  input  logic                          s_tuser,     // checksum_ok
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [srr_pkg::TDATA_W-1:0]   m_tdata,     // ack_num[2:0], data[66:3]
  output logic                          m_tuser,     // kind
  output logic                          m_tlast      // last
);

  import srr_pkg::*;

  srr_cmd_t          cmd;
  srr_status_t       st;
  logic [SEQ_W-1:0]  out_ack;
  logic [DATA_W-1:0] out_data;

  srr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  srr_dp #(
    .SEQ_SPACE    (SEQ_SPACE),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .seq_num     (s_tdata[SEQ_W-1:0]),
    .checksum_ok (s_tuser),
    .payload     (s_tdata[SEQ_W +: DATA_W]),
    .cmd         (cmd),
    .st          (st),
    .m_tready    (m_tready),
    .m_tvalid    (m_tvalid),
    .out_kind    (m_tuser),
    .out_ack     (out_ack),
    .out_data    (out_data),
    .out_last    (m_tlast)
  );

  assign m_tdata = {(TDATA_W - SEQ_W - DATA_W)'(0), out_data, out_ack};

  // one packet in flight
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second transfer accepted while a packet is in work");

  // results are loaded only when the output register can take them
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.eval_load || cmd.dlv_load) |-> st.out_free)
    else $error("result loaded over a pending one");

  a_cmd_excl: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.eval_load, cmd.dlv_load, cmd.rd_en}))
    else $error("conflicting datapath commands");

  // a bad-checksum packet is dropped without producing a result
  a_drop_bad: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tuser |=> ##1 s_tready && !cmd.eval_load)
    else $error("bad-checksum packet not dropped");

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the selective-repeat ARQ receiver core. Packets go in on the
// input stream and a reorder-window predictor in this file works out the acks
// and in-order deliveries. A monitor compares every output transfer with them.
// Directed cases come first: bad checksums, echo acks, out-of-order runs, the
// longest delivery run, window extremes, a shrunk window with held slots and
// one long output hold. Random traffic follows under several window sizes,
// with random stalls on both streams.
// ----------------------------------------------------------------------------
module tb_top;
  import srr_pkg::*;

  localparam int SETTLE_CYCLES = 24;    // worst packet: 8 deliveries
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 3000;
  localparam int REPORT_MAX    = 10;

  typedef struct packed {
    logic              kind;
    logic [SEQ_W-1:0]  ack_num;
    logic [DATA_W-1:0] data;
    logic              last;
  } arq_result_t;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                cfg_we    = 1'b0;
  logic [CFG_W-1:0]    cfg_wdata = '0;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [TDATA_W-1:0]  s_tdata   = '0;   // seq_num[2:0], payload[66:3]
  logic                s_tuser   = 1'b0; // checksum_ok
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [TDATA_W-1:0]  m_tdata;          // ack_num[2:0], data[66:3]
  logic                m_tuser;          // kind
  logic                m_tlast;          // last

  // Receive-window state as the block should hold it
  logic [CFG_W-1:0]  rx_window = WINDOW_RESET;
  logic [SEQ_W-1:0]  rx_base   = '0;
  logic              rx_marked [8];
  logic [DATA_W-1:0] rx_slot   [8];
  arq_result_t       arq_outbox[$];

  bit src_idle_en   = 1'b1;
  bit sink_stall_en = 1'b1;
  int holds_asked   = 0;
  int errors        = 0;
  int packets_sent  = 0;
  int acks_seen     = 0;
  int dlvs_seen     = 0;
  int window_writes = 0;
  int quiet_cycles  = 0;

  selective_repeat_receiver_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  always #10 clk = ~clk;

  initial begin
    for (int i = 0; i < 8; i++) rx_marked[i] = 1'b0;
  end

  // Drop bad packets; ack the rest, store in-window ones, then deliver the run
  function automatic void arq_accept_packet(input logic [SEQ_W-1:0] seq, input logic ok,
                                            input logic [DATA_W-1:0] pay);
    logic [SEQ_W-1:0] win_off;
    arq_result_t      r;
    int               n;
    if (!ok) return;
    win_off = seq - rx_base;
    if (!(win_off < rx_window)) begin
      arq_outbox.push_back('{KIND_ACK, seq, '0, 1'b1});
      return;
    end
    rx_slot[seq]   = pay;
    rx_marked[seq] = 1'b1;
    r = '{KIND_ACK, seq, '0, 1'b0};
    n = 1;
    while (n < MAX_RESULTS && rx_marked[rx_base]) begin
      arq_outbox.push_back(r);
      r = '{KIND_DELIVER, '0, rx_slot[rx_base], 1'b0};
      rx_marked[rx_base] = 1'b0;
      rx_base = rx_base + 1'b1;
      n++;
    end
    r.last = 1'b1;
    arq_outbox.push_back(r);
  endfunction

  task automatic send_packet(input logic [SEQ_W-1:0] seq, input logic ok,
                             input logic [DATA_W-1:0] pay);
    if (src_idle_en && $urandom_range(0, 99) < 21) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(TDATA_W - DATA_W - SEQ_W){1'b0}}, pay, seq};
    s_tuser  <= ok;
    do @(posedge clk); while (!s_tready);
    arq_accept_packet(seq, ok, pay);
    packets_sent++;
  endtask

  // Stop offering and wait out every pending result plus the block's own tail
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (arq_outbox.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_window(input logic [CFG_W-1:0] w);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we    <= 1'b0;
    rx_window = w;
    window_writes++;
  endtask

  function automatic logic [DATA_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  task automatic test_reset_window();
    send_packet(3'd0, 1'b0, '1);          // bad checksum: dropped
    send_packet(3'd0, 1'b1, '1);          // in order: ack and deliver
    send_packet(3'd5, 1'b1, rand_word()); // beyond the window edge: echo
    send_packet(3'd3, 1'b1, 64'h5555_5555_5555_5555);
    send_packet(3'd2, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA);
    send_packet(3'd1, 1'b1, rand_word()); // fills the gap: run of three
    send_packet(3'd4, 1'b1, '0);
    send_packet(3'd4, 1'b1, rand_word()); // duplicate, now behind the window
    send_packet(3'd6, 1'b0, '1);
  endtask

  // Base is 5 here: hold seven slots, then fill the base for a full run
  task automatic test_full_run();
    set_window(CFG_W'(8));
    for (int i = 1; i < 8; i++) send_packet(rx_base + SEQ_W'(i), 1'b1, rand_word());
    send_packet(rx_base, 1'b1, rand_word());
  endtask

  task automatic test_window_extremes();
    set_window(CFG_W'(0));
    send_packet(rx_base, 1'b1, rand_word());
    send_packet(3'd7, 1'b1, rand_word());
    set_window(CFG_W'(15));
    send_packet(rx_base + 3'd7, 1'b1, rand_word());
    send_packet(rx_base, 1'b1, rand_word());
    set_window(CFG_W'(1));
    send_packet(rx_base + 3'd1, 1'b1, rand_word());
    send_packet(rx_base, 1'b1, rand_word());
  endtask

  // Held slots survive a shrink and go out once the run reaches them
  task automatic test_window_shrink();
    set_window(CFG_W'(8));
    send_packet(rx_base + 3'd2, 1'b1, rand_word());
    send_packet(rx_base + 3'd3, 1'b1, rand_word());
    set_window(CFG_W'(1));
    send_packet(rx_base + 3'd3, 1'b1, rand_word());
    send_packet(rx_base + 3'd1, 1'b1, rand_word());
    send_packet(rx_base, 1'b1, rand_word());
    send_packet(rx_base, 1'b1, rand_word());
  endtask

  // Hold the output while the sender keeps pushing, then pause until drained
  task automatic test_backpressure();
    set_window(CFG_W'(8));
    holds_asked++;
    for (int i = 0; i < 12; i++)
      send_packet(rx_base + SEQ_W'($urandom_range(0, 7)), 1'b1, rand_word());
    drain_results();
  endtask

  task automatic random_phase(input logic [CFG_W-1:0] w, input int count);
    int               roll;
    int               span;
    logic [SEQ_W-1:0] seq;
    logic             ok;
    logic [DATA_W-1:0] pay;
    set_window(w);
    span = (rx_window > 8) ? 8 : int'(rx_window);
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      ok   = 1'b1;
      if (roll < 70 && span > 0) seq = rx_base + SEQ_W'($urandom_range(0, span - 1));
      else seq = SEQ_W'($urandom);
      if (roll >= 85) ok = 1'b0;
      case ($urandom_range(0, 9))
        0:       pay = '0;
        1:       pay = '1;
        default: pay = rand_word();
      endcase
      send_packet(seq, ok, pay);
      if (i == count / 2 && $urandom_range(0, 1) == 1) drain_results();
    end
  endtask

  task automatic test_random_traffic();
    random_phase(CFG_W'(4), 40);
    random_phase(CFG_W'(8), 50);
    src_idle_en   = 1'b0;
    sink_stall_en = 1'b0;
    random_phase(CFG_W'(6), 50);
    src_idle_en   = 1'b1;
    sink_stall_en = 1'b1;
    random_phase(CFG_W'(1), 35);
    random_phase(CFG_W'(15), 35);
    random_phase(CFG_W'(0), 15);
    random_phase(CFG_W'($urandom_range(2, 7)), 34);
  endtask

  // Output ready: random stalls, plus a long hold when a test asks for one
  initial begin
    int hold_left;
    int holds_served;
    hold_left    = 0;
    holds_served = 0;
    forever begin
      @(posedge clk);
      if (holds_served != holds_asked) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (sink_stall_en && $urandom_range(0, 99) < 21) begin
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic note_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    errors++;
    if (errors <= REPORT_MAX)
      $display("MISMATCH %s: expected %h, actual %h (result %0d)", what, want, got,
               acks_seen + dlvs_seen);
  endtask

  always @(posedge clk) begin
    arq_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (arq_outbox.size() == 0) begin
        note_mismatch("unexpected result, tdata", '0, m_tdata[63:0]);
      end else begin
        want = arq_outbox.pop_front();
        if (m_tuser !== want.kind) note_mismatch("kind", 64'(want.kind), 64'(m_tuser));
        if (m_tdata[SEQ_W-1:0] !== want.ack_num)
          note_mismatch("ack_num", 64'(want.ack_num), 64'(m_tdata[SEQ_W-1:0]));
        if (m_tdata[SEQ_W +: DATA_W] !== want.data)
          note_mismatch("data", want.data, m_tdata[SEQ_W +: DATA_W]);
        if (m_tlast !== want.last) note_mismatch("last", 64'(want.last), 64'(m_tlast));
      end
      if (m_tuser === KIND_DELIVER) dlvs_seen++;
      else acks_seen++;
    end
  end

  // Watchdog: end the run when neither stream moves for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles, %0d results pending", STALL_LIMIT,
               arq_outbox.size());
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_window();
    test_full_run();
    test_window_extremes();
    test_window_shrink();
    test_backpressure();
    test_random_traffic();
    drain_results();
    $display("Covered %0d packets over %0d window writes: %0d acks, %0d deliveries.",
             packets_sent, window_writes, acks_seen, dlvs_seen);
    $display("Mismatches: %0d", errors);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
